/* src/tfcl_pkg.sv */
// Package for the threshold feature coordinate list block.
// Holds the result beat type, configuration types and register index codes.
// No dependencies.
package tfcl_pkg;

  // Coordinate counters hold 12 bits, so a frame side is at most this long
  localparam int CntCap = 4096;

  localparam int PixW   = 8;
  localparam int CoordW = 12;
  localparam int SizeW  = 13;
  localparam int CountW = 25;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] REG_FRAME_ROWS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_COLS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HIT_THRESHOLD = 2'd2;

  localparam logic [SizeW-1:0] ROWS_RST      = 13'd1080;
  localparam logic [SizeW-1:0] COLS_RST      = 13'd1920;
  localparam logic [PixW-1:0]  THRESHOLD_RST = 8'd128;

  // Beat kinds
  localparam logic KIND_FEATURE = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Result queue geometry: holds two items' worth of worst-case bursts
  localparam int QDepth = 8;
  localparam int QPtrW  = 3;
  localparam int QCntW  = 4;
  localparam int MaxBeatsPerItem = 3;

  typedef struct packed {
    logic              beat_kind;
    logic [CoordW-1:0] feature_row;
    logic [CoordW-1:0] feature_col;
    logic              first_flag;
    logic              last_flag;
    logic [CountW-1:0] found_count;
  } tfcl_beat_t;

  typedef struct packed {
    logic [SizeW-1:0] frame_rows;
    logic [SizeW-1:0] frame_cols;
    logic [PixW-1:0]  hit_threshold;
  } tfcl_cfg_t;

  // Beats produced by one item, packed to the front, with their count
  typedef struct packed {
    logic [1:0]            n;
    tfcl_beat_t [2:0]      beat;
  } tfcl_push_t;

endpackage

/* src/tfcl_if.sv */
// Channel interfaces for the threshold feature coordinate list block.
// Depends on tfcl_pkg for field widths.
interface tfcl_pix_if import tfcl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface tfcl_beat_if import tfcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              beat_kind;
  logic [CoordW-1:0] feature_row;
  logic [CoordW-1:0] feature_col;
  logic              first_flag;
  logic              last_flag;
  logic [CountW-1:0] found_count;

  modport source (output valid, output beat_kind, output feature_row, output feature_col,
                  output first_flag, output last_flag, output found_count, input ready);
  modport sink   (input valid, input beat_kind, input feature_row, input feature_col,
                  input first_flag, input last_flag, input found_count, output ready);
endinterface

/* src/threshold_feature_coordinate_list.sv */
// Threshold feature coordinate list: top level.
// A taken pixel goes through the input register; the core's beats for it are then written into the queue.
// Throughput: one pixel per cycle while the 8-entry result queue holds two beats or fewer; input
// pauses when out_chan is held off or beats pile up faster than one per cycle (dense features,
// frames of a few pixels, where a frame end adds up to three beats).
// Reset (synchronous, rst_n low): queue emptied, frame state cleared, 1080x1920, threshold 128.
module threshold_feature_coordinate_list import tfcl_pkg::*; #(
  parameter int MAX_ROWS_P = 4096,
  parameter int MAX_COLS_P = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  tfcl_pix_if.sink            in_chan,
  tfcl_beat_if.source         out_chan,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  tfcl_cfg_t        cfg_r;
  logic [PixW-1:0]  pix_r;
  logic             pix_vld_r;
  logic             take;
  tfcl_push_t       push;
  logic [QCntW-1:0] q_count;
  logic             q_not_empty;
  tfcl_beat_t       head;

  // Room for the staged item's burst plus one more
  assign in_chan.ready = (q_count <= QCntW'(QDepth - 2 * MaxBeatsPerItem));
  assign take          = in_chan.valid && in_chan.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_rows    <= ROWS_RST;
      cfg_r.frame_cols    <= COLS_RST;
      cfg_r.hit_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ROWS:    cfg_r.frame_rows    <= cfg_data[SizeW-1:0];
        REG_FRAME_COLS:    cfg_r.frame_cols    <= cfg_data[SizeW-1:0];
        REG_HIT_THRESHOLD: cfg_r.hit_threshold <= cfg_data[PixW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) pix_vld_r <= 1'b0;
    else        pix_vld_r <= take;
  end

  always_ff @(posedge clk) begin
    if (take) pix_r <= in_chan.pixel_value;
  end

  tfcl_core #(
    .MAX_ROWS_P(MAX_ROWS_P),
    .MAX_COLS_P(MAX_COLS_P)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (pix_vld_r),
    .pix      (pix_r),
    .cfg      (cfg_r),
    .push     (push)
  );

  tfcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_chan.ready),
    .not_empty (q_not_empty),
    .count     (q_count),
    .head      (head)
  );

  // Result channel
  assign out_chan.valid       = q_not_empty;
  assign out_chan.beat_kind   = head.beat_kind;
  assign out_chan.feature_row = head.feature_row;
  assign out_chan.feature_col = head.feature_col;
  assign out_chan.first_flag  = head.first_flag;
  assign out_chan.last_flag   = head.last_flag;
  assign out_chan.found_count = head.found_count;

endmodule

/* src/tfcl_core.sv */
// Raster position tracking, threshold test and one-beat lookahead.
// Produces up to three beats per pixel. Depends on tfcl_pkg.
module tfcl_core import tfcl_pkg::*; #(
  parameter int MAX_ROWS_P = 4096,
  parameter int MAX_COLS_P = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_vld,
  input  logic [PixW-1:0] pix,
  input  tfcl_cfg_t       cfg,
  output tfcl_push_t      push
);

  localparam int RowLimI = (MAX_ROWS_P < 1) ? 1 : ((MAX_ROWS_P < CntCap) ? MAX_ROWS_P : CntCap);
  localparam int ColLimI = (MAX_COLS_P < 1) ? 1 : ((MAX_COLS_P < CntCap) ? MAX_COLS_P : CntCap);
  localparam logic [SizeW-1:0] ROW_LIM = SizeW'(RowLimI);
  localparam logic [SizeW-1:0] COL_LIM = SizeW'(ColLimI);

  logic [CoordW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CoordW-1:0] held_row_r, held_row_nxt, held_col_r, held_col_nxt;
  logic              held_first_r, held_first_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic              first_pend_r, first_pend_nxt;
  logic [CountW-1:0] total_r, total_nxt;

  logic [SizeW-1:0]  rows_eff, cols_eff;
  logic              hit, col_end, frame_end;
  logic              v0, v1, v2;
  tfcl_beat_t        b0, b1, b2;

  // Clamp the configured frame size to 1..limit
  always_comb begin
    rows_eff = (cfg.frame_rows == '0) ? SizeW'(1) : cfg.frame_rows;
    if (rows_eff > ROW_LIM) rows_eff = ROW_LIM;
    cols_eff = (cfg.frame_cols == '0) ? SizeW'(1) : cfg.frame_cols;
    if (cols_eff > COL_LIM) cols_eff = COL_LIM;
  end

  // Per-pixel decision and next state
  always_comb begin
    hit       = (pix >= cfg.hit_threshold);
    col_end   = ({1'b0, col_r} + SizeW'(1)) >= cols_eff;
    frame_end = col_end && (({1'b0, row_r} + SizeW'(1)) >= rows_eff);

    col_nxt        = col_r;
    row_nxt        = row_r;
    held_row_nxt   = held_row_r;
    held_col_nxt   = held_col_r;
    held_first_nxt = held_first_r;
    held_vld_nxt   = held_vld_r;
    first_pend_nxt = first_pend_r;
    total_nxt      = total_r;

    // displaced lookahead beat
    v0 = item_vld && hit && held_vld_r;
    b0 = '{beat_kind: KIND_FEATURE, feature_row: held_row_r, feature_col: held_col_r,
           first_flag: held_first_r, last_flag: 1'b0, found_count: '0};

    if (hit) begin
      held_row_nxt   = row_r;
      held_col_nxt   = col_r;
      held_first_nxt = first_pend_r;
      held_vld_nxt   = 1'b1;
      first_pend_nxt = 1'b0;
      total_nxt      = total_r + CountW'(1);
    end

    // frame end: flush the held feature as last, then the count report
    v1 = item_vld && frame_end && held_vld_nxt;
    b1 = '{beat_kind: KIND_FEATURE, feature_row: held_row_nxt, feature_col: held_col_nxt,
           first_flag: held_first_nxt, last_flag: 1'b1, found_count: '0};
    v2 = item_vld && frame_end;
    b2 = '{beat_kind: KIND_REPORT, feature_row: '0, feature_col: '0,
           first_flag: 1'b0, last_flag: 1'b0, found_count: total_nxt};

    if (col_end) begin
      col_nxt = '0;
      if (frame_end) begin
        row_nxt        = '0;
        held_vld_nxt   = 1'b0;
        held_first_nxt = 1'b0;
        first_pend_nxt = 1'b1;
        total_nxt      = '0;
      end else begin
        row_nxt = row_r + CoordW'(1);
      end
    end else begin
      col_nxt = col_r + CoordW'(1);
    end

    // Pack valid beats to the front; a last beat always comes with a report
    push.n       = 2'(v0) + 2'(v1) + 2'(v2);
    push.beat[0] = v0 ? b0 : (v1 ? b1 : b2);
    push.beat[1] = v0 ? (v1 ? b1 : b2) : b2;
    push.beat[2] = b2;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      held_vld_r   <= 1'b0;
      first_pend_r <= 1'b1;
      total_r      <= '0;
    end else if (item_vld) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      held_vld_r   <= held_vld_nxt;
      first_pend_r <= first_pend_nxt;
      total_r      <= total_nxt;
    end
  end

  // Held coordinates are only read while held_vld_r is set
  always_ff @(posedge clk) begin
    if (item_vld) begin
      held_row_r   <= held_row_nxt;
      held_col_r   <= held_col_nxt;
      held_first_r <= held_first_nxt;
    end
  end

endmodule

/* src/tfcl_queue.sv */
// Result queue: takes up to three beats per cycle, hands out one per cycle while pop is high.
// Depends on tfcl_pkg.
module tfcl_queue import tfcl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tfcl_push_t       push,
  input  logic             pop,
  output logic             not_empty,
  output logic [QCntW-1:0] count,
  output tfcl_beat_t       head
);

  tfcl_beat_t       mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;
  assign cnt_nxt   = cnt_r + QCntW'(push.n) - QCntW'(do_pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrW'(push.n);
      rd_ptr_r <= rd_ptr_r + QPtrW'(do_pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage: consecutive slots from the write pointer
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxBeatsPerItem; i++) begin
      if (2'(i) < push.n) mem_r[wr_ptr_r + QPtrW'(i)] <= push.beat[i];
    end
  end

endmodule

/* src/tfcl_checker.sv */
// Port-level checks for the threshold feature coordinate list, bound to the top level.
// Depends on tfcl_pkg and the top level's channel interfaces.
module tfcl_checker import tfcl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              beat_kind,
  input logic [CoordW-1:0] feature_row,
  input logic [CoordW-1:0] feature_col,
  input logic              first_flag,
  input logic              last_flag,
  input logic [CountW-1:0] found_count
);

  // Report beats carry only the count
  a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && beat_kind == KIND_REPORT |->
      feature_row == '0 && feature_col == '0 && !first_flag && !last_flag)
    else $error("report beat carries coordinate or flag bits");

  // Feature beats carry no count
  a_feature_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && beat_kind == KIND_FEATURE |-> found_count == '0)
    else $error("feature beat carries a count");

  // The last feature of a frame is immediately followed by its report
  a_last_then_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && beat_kind == KIND_FEATURE && last_flag |=>
      out_valid && beat_kind == KIND_REPORT)
    else $error("last feature not followed by count report");

  // Reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

endmodule

bind threshold_feature_coordinate_list tfcl_checker u_tfcl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .beat_kind   (out_chan.beat_kind),
  .feature_row (out_chan.feature_row),
  .feature_col (out_chan.feature_col),
  .first_flag  (out_chan.first_flag),
  .last_flag   (out_chan.last_flag),
  .found_count (out_chan.found_count)
);

/* tb/sv/tb_top.sv */
// Testbench for threshold_feature_coordinate_list: directed table, then random phases.
// Every accepted beat is checked against expected beats from the directed table or a built-in predictor.
// Depends on tfcl_pkg, tfcl_if and the RTL top level.
module tb_top;
  import tfcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 330;
  localparam int TAIL_ITEMS  = 60;       // final random items run without idling
  localparam int SETTLE_CYC  = 6;        // pipeline latency plus margin
  localparam int CYCLE_LIMIT = 600000;

  // Index with no register behind it
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_PIX, ROW_PIX_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   val;
    logic [PixW-1:0]       pix;
    int                    n_want;
    tfcl_beat_t            want [3];
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  tfcl_pix_if  pix_if ();
  tfcl_beat_if beat_if ();

  threshold_feature_coordinate_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (pix_if),
    .out_chan  (beat_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and the frame state
  logic [SizeW-1:0]  set_rows = ROWS_RST;
  logic [SizeW-1:0]  set_cols = COLS_RST;
  logic [PixW-1:0]   set_thr  = THRESHOLD_RST;
  logic [CoordW-1:0] pos_col = '0;
  logic [CoordW-1:0] pos_row = '0;
  logic [CoordW-1:0] pend_row = '0;
  logic [CoordW-1:0] pend_col = '0;
  logic              pend_first = 1'b0;
  logic              pend_valid = 1'b0;
  logic              first_due = 1'b1;
  logic [CountW-1:0] hit_count = '0;

  tfcl_beat_t beats_due[$];
  stim_row_t  dir_tab[$];

  bit          idle_on = 1'b1;
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          coord_beats = 0;
  int          frame_reports = 0;
  int          reg_writes = 0;
  int unsigned cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic tfcl_beat_t mk_coord(int r, int c, bit f, bit l);
    tfcl_beat_t b;
    b = '0;
    b.beat_kind   = KIND_FEATURE;
    b.feature_row = CoordW'(r);
    b.feature_col = CoordW'(c);
    b.first_flag  = f;
    b.last_flag   = l;
    return b;
  endfunction

  function automatic tfcl_beat_t mk_report(int n);
    tfcl_beat_t b;
    b = '0;
    b.beat_kind   = KIND_REPORT;
    b.found_count = CountW'(n);
    return b;
  endfunction

  // Zero acts as one; anything past the counter span acts as 4096
  function automatic int unsigned eff_size(logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (v > CntCap) return CntCap;
    return v;
  endfunction

  function automatic void clear_frame();
    pos_col    = '0;
    pos_row    = '0;
    pend_row   = '0;
    pend_col   = '0;
    pend_first = 1'b0;
    pend_valid = 1'b0;
    first_due  = 1'b1;
    hit_count  = '0;
  endfunction

  function automatic void note_beat(bit record, tfcl_beat_t b);
    if (record) beats_due.push_back(b);
  endfunction

  // Advance the frame by one pixel; queue the beats it releases when record is set
  function automatic void extract_features(logic [PixW-1:0] pix, bit record);
    int unsigned rows_eff;
    int unsigned cols_eff;
    rows_eff = eff_size(set_rows);
    cols_eff = eff_size(set_cols);
    if (pix >= set_thr) begin
      // a new feature pushes the held one out
      if (pend_valid) note_beat(record, mk_coord(pend_row, pend_col, pend_first, 1'b0));
      pend_row   = pos_row;
      pend_col   = pos_col;
      pend_first = first_due;
      pend_valid = 1'b1;
      first_due  = 1'b0;
      hit_count  = hit_count + 1'b1;
    end
    if (int'(pos_col) + 1 >= cols_eff) begin
      pos_col = '0;
      if (int'(pos_row) + 1 >= rows_eff) begin
        if (pend_valid) note_beat(record, mk_coord(pend_row, pend_col, pend_first, 1'b1));
        note_beat(record, mk_report(hit_count));
        clear_frame();
      end else begin
        pos_row = pos_row + 1'b1;
      end
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: check accepted beats, then pick the next ready value
  int stall_left = 0;
  always @(posedge clk) begin
    tfcl_beat_t want;
    if (!rst_n) begin
      beat_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (beat_if.valid && beat_if.ready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected beat: kind %0d row %0d col %0d count %0d", beat_if.beat_kind,
                 beat_if.feature_row, beat_if.feature_col, beat_if.found_count);
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          check_field("beat_kind", want.beat_kind, beat_if.beat_kind);
          check_field("feature_row", want.feature_row, beat_if.feature_row);
          check_field("feature_col", want.feature_col, beat_if.feature_col);
          check_field("first_flag", want.first_flag, beat_if.first_flag);
          check_field("last_flag", want.last_flag, beat_if.last_flag);
          check_field("found_count", want.found_count, beat_if.found_count);
          if (want.beat_kind == KIND_REPORT) frame_reports++;
          else coord_beats++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        beat_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        beat_if.ready <= 1'b0;
      end else begin
        beat_if.ready <= 1'b1;
      end
    end
  end

  // Offer one pixel, with an occasional gap before it, and predict once it is taken
  task automatic send_pixel(input logic [PixW-1:0] pix, input bit record);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pix;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pixels_sent++;
    extract_features(pix, record);
  endtask

  // Hold off the sender until every expected beat is out and the pipe is empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes need no toggle; caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_ROWS:    set_rows = val;
      REG_FRAME_COLS:    set_cols = val;
      REG_HIT_THRESHOLD: set_thr  = val[PixW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [SizeW-1:0] pick_size(int small_max);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return SizeW'($urandom_range(4097, 8191));
      2:       return 13'd4096;
      3:       return 13'd8191;
      default: return SizeW'($urandom_range(1, small_max));
    endcase
  endfunction

  // Upper data bits are random: only the low byte lands in the register
  function automatic logic [CfgDataW-1:0] pick_threshold();
    logic [PixW-1:0] t;
    case ($urandom_range(0, 5))
      0:       t = 8'd0;
      1:       t = 8'd255;
      default: t = 8'($urandom_range(0, 255));
    endcase
    return {5'($urandom), t};
  endfunction

  // Bias pixels toward the threshold edge
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return set_thr;
      3:       return set_thr - 1'b1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    stim_row_t r;
    r.kind   = ROW_CFG;
    r.idx    = idx;
    r.val    = val;
    r.pix    = '0;
    r.n_want = 0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_pix(logic [PixW-1:0] pix);
    stim_row_t r;
    r.kind   = ROW_PIX;
    r.idx    = '0;
    r.val    = '0;
    r.pix    = pix;
    r.n_want = 0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_typed(logic [PixW-1:0] pix, int n,
                                    tfcl_beat_t b0, tfcl_beat_t b1, tfcl_beat_t b2);
    stim_row_t r;
    r.kind    = ROW_PIX_TYPED;
    r.idx     = '0;
    r.val     = '0;
    r.pix     = pix;
    r.n_want  = n;
    r.want[0] = b0;
    r.want[1] = b1;
    r.want[2] = b2;
    dir_tab.push_back(r);
  endfunction

  // Stimulus
  initial begin
    stim_row_t row;
    int        rand_sent;
    int        burst;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_value <= '0;

    // Directed table, starting from the reset frame of 1080 x 1920, threshold 128
    add_typed(8'd0,   0, '0, '0, '0);
    add_typed(8'd255, 0, '0, '0, '0);
    // zero sizes act as one: shrink closes the open frame on the next pixel
    add_cfg(REG_FRAME_ROWS, 13'd0);
    add_cfg(REG_FRAME_COLS, 13'd0);
    add_typed(8'd0,   2, mk_coord(0, 1, 1, 1), mk_report(1), '0);
    add_typed(8'd0,   1, mk_report(0), '0, '0);
    add_typed(8'd255, 2, mk_coord(0, 0, 1, 1), mk_report(1), '0);
    add_cfg(REG_HIT_THRESHOLD, 13'd0);
    add_typed(8'd0,   2, mk_coord(0, 0, 1, 1), mk_report(1), '0);
    // one row of three, three beats out of one pixel
    add_cfg(REG_HIT_THRESHOLD, 13'd255);
    add_cfg(REG_FRAME_ROWS, 13'd1);
    add_cfg(REG_FRAME_COLS, 13'd3);
    add_typed(8'd255, 0, '0, '0, '0);
    add_typed(8'd254, 0, '0, '0, '0);
    add_typed(8'd255, 3, mk_coord(0, 0, 1, 0), mk_coord(0, 2, 0, 1), mk_report(2));
    // write to an unused index must change nothing; oversized sizes clamp
    add_cfg(REG_UNUSED, 13'd0);
    add_cfg(REG_FRAME_ROWS, 13'd8191);
    add_cfg(REG_FRAME_COLS, 13'd8191);
    add_typed(8'd0,   0, '0, '0, '0);
    add_typed(8'd255, 0, '0, '0, '0);
    add_typed(8'd255, 1, mk_coord(0, 1, 1, 0), '0, '0);
    add_typed(8'd255, 1, mk_coord(0, 2, 0, 0), '0, '0);
    // shrink mid-frame: first the row wraps, then the frame closes
    add_cfg(REG_FRAME_COLS, 13'd1);
    add_typed(8'd200, 0, '0, '0, '0);
    add_cfg(REG_FRAME_ROWS, 13'd1);
    add_typed(8'd0,   2, mk_coord(0, 3, 0, 1), mk_report(3), '0);
    add_cfg(REG_HIT_THRESHOLD, 13'd100);
    add_cfg(REG_FRAME_ROWS, 13'd2);
    add_cfg(REG_FRAME_COLS, 13'd2);
    add_pix(8'd99);
    add_pix(8'd100);
    add_pix(8'h55);
    add_pix(8'hAA);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_tab.size(); i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_CFG) settle();
        write_reg(row.idx, row.val);
        if (i + 1 == dir_tab.size() || dir_tab[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_pixel(row.pix, row.kind == ROW_PIX);
        for (int k = 0; k < row.n_want; k++) beats_due.push_back(row.want[k]);
      end
    end

    // Random phases: new settings at idle points, frames often left open across them
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      idle_on = (RAND_ITEMS - rand_sent > TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_ROWS, pick_size(5));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_COLS, pick_size(6));
      if ($urandom_range(0, 3) != 0) write_reg(REG_HIT_THRESHOLD, pick_threshold());
      cfg_we <= 1'b0;
      burst = $urandom_range(4, 30);
      if (burst > RAND_ITEMS - rand_sent) burst = RAND_ITEMS - rand_sent;
      repeat (burst) begin
        send_pixel(pick_pixel(), 1'b1);
        rand_sent++;
      end
    end

    settle();
    $display("Run covered %0d pixels and %0d register writes,", pixels_sent, reg_writes);
    $display("with %0d coordinate beats and %0d frame reports checked.", coord_beats,
             frame_reports);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
